[design/ttv_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// ttv_pkg
// Widths and word types shared by the triangle tangent pipeline.
// ---------------------------------------------------------------------------
package ttv_pkg;

   localparam int IN_W      = 32;
   localparam int DIFF_W    = 33;
   localparam int PROD_W    = 66;
   localparam int MAG_W     = 65;
   localparam int LEN_W     = 7;
   localparam int NORM_BITS = 30;
   localparam int SQ_W      = 60;
   localparam int SUM_W     = 62;
   localparam int ROOT_W    = 31;
   localparam int REM_W     = 33;
   localparam int FRAC_BITS = 14;
   localparam int NUM_W     = 45;
   localparam int QUO_W     = 15;
   localparam int OUT_W     = 16;

   typedef struct packed {
      logic signed [IN_W-1:0] p0_x;
      logic signed [IN_W-1:0] p0_y;
      logic signed [IN_W-1:0] p0_z;
      logic signed [IN_W-1:0] p1_x;
      logic signed [IN_W-1:0] p1_y;
      logic signed [IN_W-1:0] p1_z;
      logic signed [IN_W-1:0] p2_x;
      logic signed [IN_W-1:0] p2_y;
      logic signed [IN_W-1:0] p2_z;
      logic signed [IN_W-1:0] uv0_v;
      logic signed [IN_W-1:0] uv1_v;
      logic signed [IN_W-1:0] uv2_v;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] tangent_x;
      logic signed [OUT_W-1:0] tangent_y;
      logic signed [OUT_W-1:0] tangent_z;
      logic                    degenerate;
   } rsp_type;

endpackage
`default_nettype wire

[design/ttv_if.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// ttv_if
// Valid/ready channels carrying a triangle word and a tangent word.
// ---------------------------------------------------------------------------
interface ttv_req_if;
   import ttv_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface ttv_rsp_if;
   import ttv_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[design/triangle_tangent_vector.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// triangle_tangent_vector
// Unit tangent of one triangle from positions and texture v, Q16.16 to Q1.14.
// ---------------------------------------------------------------------------
// One triangle word enters per cycle while the output word is not held. The
// pipe is built from the 31-stage square-root recurrence (one root
// bit per stage) and the 15-stage divider lanes (one quotient bit per stage),
// plus edge, multiply, subtract, bit-length, shift, square, sum, numerator and
// output stages. All stages advance together; when the output word is held,
// the whole pipe holds and req.ready drops.
module triangle_tangent_vector (
   input  logic      clock,
   input  logic      reset,
   ttv_req_if.sink   req,
   ttv_rsp_if.source rsp
);
   import ttv_pkg::*;

   typedef struct packed {
      logic [SUM_W-1:0]                 x;
      logic [REM_W-1:0]                 rem;
      logic [ROOT_W-1:0]                root;
      logic [2:0][NORM_BITS-1:0]        m;
      logic [2:0]                       neg;
      logic                             degen;
   } sqs_type;

   typedef struct packed {
      logic [2:0][NUM_W-1:0]            num;
      logic [ROOT_W-1:0]                den;
      logic [2:0][ROOT_W-1:0]           rem;
      logic [2:0][QUO_W-1:0]            quo;
      logic [2:0]                       neg;
      logic                             degen;
   } dvs_type;

   logic adv;
   assign adv       = !rsp.valid || rsp.ready;
   assign req.ready = adv;

   // edges
   logic signed [IN_W-1:0]   pa [3];
   logic signed [IN_W-1:0]   pb [3];
   logic signed [IN_W-1:0]   pc [3];
   logic signed [DIFF_W-1:0] e1_in [3];
   logic signed [DIFF_W-1:0] e2_in [3];
   logic signed [DIFF_W-1:0] e1_ff [3];
   logic signed [DIFF_W-1:0] e2_ff [3];
   logic signed [DIFF_W-1:0] dv1_in, dv2_in, dv1_ff, dv2_ff;
   logic                     v1_ff;

   always_comb begin
      pa[0] = req.data.p0_x; pa[1] = req.data.p0_y; pa[2] = req.data.p0_z;
      pb[0] = req.data.p1_x; pb[1] = req.data.p1_y; pb[2] = req.data.p1_z;
      pc[0] = req.data.p2_x; pc[1] = req.data.p2_y; pc[2] = req.data.p2_z;
      for (int i = 0; i < 3; i++) begin
         e1_in[i] = DIFF_W'(pb[i]) - DIFF_W'(pa[i]);
         e2_in[i] = DIFF_W'(pc[i]) - DIFF_W'(pa[i]);
      end
      dv1_in = DIFF_W'(req.data.uv1_v) - DIFF_W'(req.data.uv0_v);
      dv2_in = DIFF_W'(req.data.uv2_v) - DIFF_W'(req.data.uv0_v);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req.valid;
      end
      if (adv) begin
         e1_ff  <= e1_in;
         e2_ff  <= e2_in;
         dv1_ff <= dv1_in;
         dv2_ff <= dv2_in;
      end
   end

   // products
   logic signed [PROD_W-1:0] pp_in [3];
   logic signed [PROD_W-1:0] pq_in [3];
   logic signed [PROD_W-1:0] pp_ff [3];
   logic signed [PROD_W-1:0] pq_ff [3];
   logic                     v2_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pp_in[i] = PROD_W'(dv2_ff) * PROD_W'(e1_ff[i]);
         pq_in[i] = PROD_W'(dv1_ff) * PROD_W'(e2_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
      if (adv) begin
         pp_ff <= pp_in;
         pq_ff <= pq_in;
      end
   end

   // sign and magnitude
   logic signed [PROD_W:0] df [3];
   logic signed [PROD_W:0] ab [3];
   logic [MAG_W-1:0]       mag_in [3];
   logic [MAG_W-1:0]       mag_ff [3];
   logic [2:0]             neg_in, neg_ff;
   logic                   v3_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         df[i]     = (PROD_W+1)'(pp_ff[i]) - (PROD_W+1)'(pq_ff[i]);
         neg_in[i] = df[i][PROD_W];
         ab[i]     = df[i][PROD_W] ? -df[i] : df[i];
         mag_in[i] = ab[i][MAG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
      if (adv) begin
         mag_ff <= mag_in;
         neg_ff <= neg_in;
      end
   end

   // bit length of the largest magnitude
   logic [MAG_W-1:0] orw;
   logic [LEN_W-1:0] blen_in, blen_ff;
   logic [MAG_W-1:0] mag4_ff [3];
   logic [2:0]       neg4_ff;
   logic             v4_ff;

   always_comb begin
      orw     = mag_ff[0] | mag_ff[1] | mag_ff[2];
      blen_in = '0;
      for (int i = 0; i < MAG_W; i++) begin
         if (orw[i]) begin
            blen_in = LEN_W'(i + 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= v3_ff;
      end
      if (adv) begin
         blen_ff <= blen_in;
         mag4_ff <= mag_ff;
         neg4_ff <= neg_ff;
      end
   end

   // normalize
   logic [LEN_W-1:0]     rsh, lsh;
   logic [MAG_W-1:0]     shv [3];
   logic [NORM_BITS-1:0] m_in [3];
   logic [NORM_BITS-1:0] m_ff [3];
   logic [2:0]           neg5_ff;
   logic                 dg5_ff;
   logic                 v5_ff;

   always_comb begin
      rsh = blen_ff - LEN_W'(NORM_BITS);
      lsh = LEN_W'(NORM_BITS) - blen_ff;
      for (int i = 0; i < 3; i++) begin
         if (blen_ff >= LEN_W'(NORM_BITS)) begin
            shv[i] = mag4_ff[i] >> rsh;
         end else begin
            shv[i] = mag4_ff[i] << lsh;
         end
         m_in[i] = shv[i][NORM_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (adv) begin
         v5_ff <= v4_ff;
      end
      if (adv) begin
         m_ff    <= m_in;
         neg5_ff <= neg4_ff;
         dg5_ff  <= (blen_ff == '0);
      end
   end

   // squares
   logic [SQ_W-1:0]      sq_in [3];
   logic [SQ_W-1:0]      sqr_ff [3];
   logic [NORM_BITS-1:0] m6_ff [3];
   logic [2:0]           neg6_ff;
   logic                 dg6_ff;
   logic                 v6_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = SQ_W'(m_ff[i]) * SQ_W'(m_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (adv) begin
         v6_ff <= v5_ff;
      end
      if (adv) begin
         sqr_ff  <= sq_in;
         m6_ff   <= m_ff;
         neg6_ff <= neg5_ff;
         dg6_ff  <= dg5_ff;
      end
   end

   // sum of squares, root recurrence entry
   sqs_type sq_ff   [ROOT_W+1];
   logic    sq_v_ff [ROOT_W+1];
   sqs_type sq0_in;

   always_comb begin
      sq0_in.x     = SUM_W'(sqr_ff[0]) + SUM_W'(sqr_ff[1]) + SUM_W'(sqr_ff[2]);
      sq0_in.rem   = '0;
      sq0_in.root  = '0;
      sq0_in.neg   = neg6_ff;
      sq0_in.degen = dg6_ff;
      for (int i = 0; i < 3; i++) begin
         sq0_in.m[i] = m6_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff[0] <= 1'b0;
      end else if (adv) begin
         sq_v_ff[0] <= v6_ff;
      end
      if (adv) begin
         sq_ff[0] <= sq0_in;
      end
   end

   for (genvar k = 0; k < ROOT_W; k++) begin : g_root
      logic [REM_W+1:0] tr, tv;
      sqs_type          nx;

      always_comb begin
         nx = sq_ff[k];
         tr = {sq_ff[k].rem, sq_ff[k].x[SUM_W-1-2*k -: 2]};
         tv = (REM_W+2)'({sq_ff[k].root, 2'b01});
         if (tr >= tv) begin
            nx.rem  = REM_W'(tr - tv);
            nx.root = {sq_ff[k].root[ROOT_W-2:0], 1'b1};
         end else begin
            nx.rem  = REM_W'(tr);
            nx.root = {sq_ff[k].root[ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[k+1] <= 1'b0;
         end else if (adv) begin
            sq_v_ff[k+1] <= sq_v_ff[k];
         end
         if (adv) begin
            sq_ff[k+1] <= nx;
         end
      end
   end

   // numerators, divider entry
   dvs_type dv_ff   [QUO_W+1];
   logic    dv_v_ff [QUO_W+1];
   dvs_type dv0_in;

   always_comb begin
      dv0_in.den   = sq_ff[ROOT_W].root;
      dv0_in.neg   = sq_ff[ROOT_W].neg;
      dv0_in.degen = sq_ff[ROOT_W].degen;
      for (int i = 0; i < 3; i++) begin
         dv0_in.num[i] = NUM_W'({sq_ff[ROOT_W].m[i], FRAC_BITS'(0)})
                       + NUM_W'(sq_ff[ROOT_W].root >> 1);
         dv0_in.rem[i] = ROOT_W'(dv0_in.num[i] >> QUO_W);
         dv0_in.quo[i] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_v_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_v_ff[0] <= sq_v_ff[ROOT_W];
      end
      if (adv) begin
         dv_ff[0] <= dv0_in;
      end
   end

   for (genvar j = 0; j < QUO_W; j++) begin : g_div
      logic [ROOT_W:0] tq [3];
      dvs_type         nx;

      always_comb begin
         nx = dv_ff[j];
         for (int i = 0; i < 3; i++) begin
            tq[i] = {dv_ff[j].rem[i], dv_ff[j].num[i][QUO_W-1-j]};
            if (tq[i] >= {1'b0, dv_ff[j].den}) begin
               nx.rem[i] = ROOT_W'(tq[i] - {1'b0, dv_ff[j].den});
               nx.quo[i] = {dv_ff[j].quo[i][QUO_W-2:0], 1'b1};
            end else begin
               nx.rem[i] = ROOT_W'(tq[i]);
               nx.quo[i] = {dv_ff[j].quo[i][QUO_W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[j+1] <= 1'b0;
         end else if (adv) begin
            dv_v_ff[j+1] <= dv_v_ff[j];
         end
         if (adv) begin
            dv_ff[j+1] <= nx;
         end
      end
   end

   // sign and output word
   logic [OUT_W-1:0] qq [3];
   logic [OUT_W-1:0] sv [3];
   rsp_type          out_in, out_ff;
   logic             out_v_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         qq[i] = OUT_W'(dv_ff[QUO_W].quo[i]);
         sv[i] = dv_ff[QUO_W].degen ? '0 : (dv_ff[QUO_W].neg[i] ? -qq[i] : qq[i]);
      end
      out_in.tangent_x  = sv[0];
      out_in.tangent_y  = sv[1];
      out_in.tangent_z  = sv[2];
      out_in.degenerate = dv_ff[QUO_W].degen;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= dv_v_ff[QUO_W];
      end
      if (adv) begin
         out_ff <= out_in;
      end
   end

   assign rsp.valid = out_v_ff;
   assign rsp.data  = out_ff;

endmodule
`default_nettype wire

[test/testbench.sv]
// ---------------------------------------------------------------------------
// testbench
// Drives triangle words into the tangent pipeline and checks each tangent word
// against an exact integer prediction, with random gaps and output stalls.
// ---------------------------------------------------------------------------
module testbench;
   import ttv_pkg::*;

   localparam int LATENCY   = 55;
   localparam int CYCLE_CAP = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ttv_req_if req ();
   ttv_rsp_if rsp ();

   triangle_tangent_vector u_top (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   always #4 clock = ~clock;

   rsp_type tangent_queue[$];
   int      error_count = 0;
   int      cycle_count = 0;
   int      hold_off = 0;
   bit      random_stall = 1'b0;

   initial begin
      req.valid = 1'b0;
      req.data  = '0;
      rsp.ready = 1'b0;
   end

   task automatic report(input string msg);
      $display("ERROR: %s", msg);
      error_count++;
   endtask

   function automatic logic [63:0] isqrt(input logic [63:0] x);
      logic [63:0] root;
      logic [63:0] bit_val;
      root    = 0;
      bit_val = 64'd1 << 62;
      while (bit_val > x) bit_val = bit_val >> 2;
      while (bit_val != 0) begin
         if (x >= root + bit_val) begin
            x    = x - (root + bit_val);
            root = (root >> 1) + bit_val;
         end else begin
            root = root >> 1;
         end
         bit_val = bit_val >> 2;
      end
      return root;
   endfunction

   function automatic rsp_type predict_tangent(input req_type w);
      rsp_type                r;
      logic signed [33:0]     e1 [3];
      logic signed [33:0]     e2 [3];
      logic signed [33:0]     dv1;
      logic signed [33:0]     dv2;
      logic signed [IN_W-1:0] pa [3];
      logic signed [IN_W-1:0] pb [3];
      logic signed [IN_W-1:0] pc [3];
      logic signed [69:0]     t [3];
      logic [68:0]            mag [3];
      logic [63:0]            m [3];
      logic [63:0]            len2;
      logic [63:0]            len;
      logic [63:0]            q;
      int                     lmax;
      int                     sh;
      pa = '{w.p0_x, w.p0_y, w.p0_z};
      pb = '{w.p1_x, w.p1_y, w.p1_z};
      pc = '{w.p2_x, w.p2_y, w.p2_z};
      dv1 = 34'(w.uv1_v) - 34'(w.uv0_v);
      dv2 = 34'(w.uv2_v) - 34'(w.uv0_v);
      lmax = 0;
      for (int i = 0; i < 3; i++) begin
         e1[i]  = 34'(pb[i]) - 34'(pa[i]);
         e2[i]  = 34'(pc[i]) - 34'(pa[i]);
         t[i]   = 70'(dv2) * 70'(e1[i]) - 70'(dv1) * 70'(e2[i]);
         mag[i] = t[i] < 0 ? 69'(-t[i]) : 69'(t[i]);
         for (int b = 0; b < 69; b++) if (mag[i][b] && b + 1 > lmax) lmax = b + 1;
      end
      r = '0;
      if (lmax == 0) begin
         r.degenerate = 1'b1;
         return r;
      end
      sh   = lmax - NORM_BITS;
      len2 = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = sh >= 0 ? 64'(mag[i] >> sh) : 64'(mag[i] << (-sh));
         len2 = len2 + m[i] * m[i];
      end
      len = isqrt(len2);
      for (int i = 0; i < 3; i++) begin
         q = (m[i] * 64'd16384 + (len >> 1)) / len;
         if (t[i] < 0) q = -q;
         if (i == 0) r.tangent_x = q[15:0];
         if (i == 1) r.tangent_y = q[15:0];
         if (i == 2) r.tangent_z = q[15:0];
      end
      return r;
   endfunction

   task automatic send_triangle(input req_type w);
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 2) == 0) gap = 0;
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.data  <= w;
      tangent_queue.push_back(predict_tangent(w));
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   // ready side: long hold-off when requested, random stalls when enabled, else always ready
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off--;
         rsp.ready <= 1'b0;
      end else if (random_stall) begin
         rsp.ready <= ($urandom_range(0, 9) == 0) ? 1'b0 :
                      ($urandom_range(0, 3) != 0);
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (tangent_queue.size() == 0) begin
            report("tangent word with none expected");
         end else begin
            want = tangent_queue.pop_front();
            if (rsp.data.tangent_x !== want.tangent_x)
               report($sformatf("tangent_x %0d want %0d", rsp.data.tangent_x, want.tangent_x));
            if (rsp.data.tangent_y !== want.tangent_y)
               report($sformatf("tangent_y %0d want %0d", rsp.data.tangent_y, want.tangent_y));
            if (rsp.data.tangent_z !== want.tangent_z)
               report($sformatf("tangent_z %0d want %0d", rsp.data.tangent_z, want.tangent_z));
            if (rsp.data.degenerate !== want.degenerate)
               report($sformatf("degenerate %0b want %0b", rsp.data.degenerate,
                                want.degenerate));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_CAP) begin
         $display("** triangle_tangent_vector: FAILED **");
         $finish;
      end
   end

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 32'h8000_0000 | ($urandom_range(0, 3));
         2: return 32'h7fff_ffff - $urandom_range(0, 3);
         default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      endcase
   endfunction

   function automatic req_type rand_triangle();
      req_type w;
      logic [31:0] f [12];
      for (int i = 0; i < 12; i++) f[i] = rand_coord();
      if ($urandom_range(0, 15) == 0) f[10] = f[9];
      if ($urandom_range(0, 15) == 0) f[11] = f[9];
      if ($urandom_range(0, 20) == 0) begin
         f[3] = f[0]; f[4] = f[1]; f[5] = f[2];
      end
      w = {f[0], f[1], f[2], f[3], f[4], f[5], f[6], f[7], f[8], f[9], f[10], f[11]};
      return w;
   endfunction

   task automatic wait_drained();
      req.valid <= 1'b0;
      while (tangent_queue.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      req_type w;
      logic [31:0] ext [4];
      ext = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff};
      w = '0;
      send_triangle(w);
      w = '0; w.p1_x = 32'h0001_0000; w.p2_y = 32'h0001_0000; w.uv1_v = 32'h0001_0000;
      send_triangle(w);
      w.uv2_v = 32'h0001_0000;
      send_triangle(w);
      for (int a = 0; a < 4; a++)
         for (int b = 0; b < 4; b++) begin
            w = {{3{ext[a]}}, {3{ext[b]}}, {3{ext[3 - a]}}, ext[b], ext[a], ext[(a + b) % 4]};
            send_triangle(w);
         end
      w = {32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, {3{32'h8000_0000}},
           {3{32'h7fff_ffff}}, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000};
      send_triangle(w);
      w = '1;
      send_triangle(w);
      wait_drained();
   endtask

   task automatic test_backpressure();
      hold_off = 10 * LATENCY;
      for (int i = 0; i < 90; i++) send_triangle(rand_triangle());
      wait_drained();
   endtask

   task automatic test_random();
      random_stall = 1'b1;
      for (int i = 0; i < 760; i++) begin
         send_triangle(rand_triangle());
         if (i == 380) wait_drained();
      end
      wait_drained();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_random();
      repeat (LATENCY + 10) @(posedge clock);
      if (error_count == 0 && tangent_queue.size() == 0) begin
         $display("** triangle_tangent_vector: PASSED **");
      end else begin
         $display("** triangle_tangent_vector: FAILED **");
      end
      $finish;
   end

endmodule
